>>> rtl/assert_macros.svh
// Assertion macros used by the top level RTL.
// Checks compile only when SYNTHESIS is not defined; otherwise they are empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define FPSS_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fpss check failed");

// Consequent must hold in the cycle after the antecedent.
`define FPSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpss sequence check failed");

`else

`define FPSS_ASSERT(label, clk, rst, cond)
`define FPSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/fpss_pkg.sv
// Package for the five point stencil step block.
// Default sizes, gain register constants and the result tag type. No dependencies.
`timescale 1ns / 1ps

package fpss_pkg;

  localparam int GRID_SIZE_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int GAIN_BITS       = 16;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd16384;

  // Per-result control carried down the arithmetic pipeline.
  typedef struct packed {
    logic interior;
    logic end_of_run;
    logic frame_done;
  } tag_t;

endpackage

>>> rtl/five_point_stencil_step_top.sv
// Top level of the five point stencil step: raster counters, row flush, gain register.
// Depends on fpss_pkg, fpss_line, fpss_datapath and assert_macros.svh.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  sample   | sample_valid / sample_stall | sample
//  result   | result_valid / result_stall | new_value, end_of_run, frame_done
//  config   | cfg_write                   | cfg_data (diffusion gain)
//
// One sample per cycle while sample_stall is low; the last sample of a grid starts the
// flush that pushes the zero final row through the pipeline, one per cycle while
// it is ready. Samples past row 0 pass the sum, multiply and clamp registers in turn.
// Reset clears counters, flush count and pipeline valids and loads the gain with 16384;
// the delay line is not reset. A result stall backs up through the pipeline ready chain,
// so samples keep being taken while pipeline stages are empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module five_point_stencil_step_top #(
  parameter int GRID_SIZE   = fpss_pkg::GRID_SIZE_DEF,
  parameter int SAMPLE_BITS = fpss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [fpss_pkg::GAIN_BITS-1:0] cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [SAMPLE_BITS-1:0]  new_value,
  output logic                           end_of_run,
  output logic                           frame_done
);

  import fpss_pkg::*;

  localparam int CW = $clog2(GRID_SIZE);
  localparam int FW = $clog2(GRID_SIZE + 1);
  localparam logic [CW-1:0] LAST_POS = CW'(GRID_SIZE - 1);
  localparam logic [CW-1:0] EDGE_POS = CW'(GRID_SIZE - 2);
  localparam logic [FW-1:0] FLUSH_LEN = FW'(GRID_SIZE);

  logic [GAIN_BITS-1:0] gain;
  logic [CW-1:0]        col, row;
  logic [CW-1:0]        col_next, row_next;
  logic [FW-1:0]        flush_cnt;
  logic                 flushing;
  logic                 push_ready;
  logic                 push;
  logic                 sample_xfer;
  logic                 final_in;
  tag_t                 tag;
  tag_t                 res_tag;
  logic signed [SAMPLE_BITS-1:0] t_up, t_left, t_center, t_right;

  assign flushing     = flush_cnt != '0;
  assign sample_stall = flushing || !push_ready;
  assign sample_xfer  = sample_valid && !sample_stall;
  assign final_in     = (row == LAST_POS) && (col == LAST_POS);
  assign push         = (sample_xfer && row != '0) || (flushing && push_ready);

  always_comb begin
    if (flushing) begin
      tag.interior   = 1'b0;
      tag.end_of_run = flush_cnt == FW'(1);
      tag.frame_done = flush_cnt == FW'(1);
    end else begin
      // cell (row-1, col) is interior when row-1 is at least 1 and col is 1 to GRID_SIZE-2
      tag.interior   = (row >= CW'(2)) && (col != '0) && (col <= EDGE_POS);
      tag.end_of_run = !final_in;
      tag.frame_done = 1'b0;
    end
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (final_in) begin
      col_next = '0;
      row_next = '0;
    end else if (col == LAST_POS) begin
      col_next = '0;
      row_next = row + CW'(1);
    end else begin
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RESET;
      col       <= '0;
      row       <= '0;
      flush_cnt <= '0;
    end else begin
      if (cfg_write) begin
        gain <= cfg_data;
      end
      if (sample_xfer) begin
        col <= col_next;
        row <= row_next;
      end
      if (sample_xfer && final_in) begin
        flush_cnt <= FLUSH_LEN;
      end else if (flushing && push_ready) begin
        flush_cnt <= flush_cnt - FW'(1);
      end
    end
  end

  fpss_line #(.N(GRID_SIZE), .W(SAMPLE_BITS)) u_line (
    .clk    (clk),
    .en     (sample_xfer),
    .d      (sample),
    .up     (t_up),
    .left   (t_left),
    .center (t_center),
    .right  (t_right)
  );

  fpss_datapath #(.W(SAMPLE_BITS)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .gain       (gain),
    .push       (push),
    .push_ready (push_ready),
    .up         (t_up),
    .down       (sample),
    .left       (t_left),
    .right      (t_right),
    .center     (t_center),
    .tag        (tag),
    .out_valid  (result_valid),
    .out_stall  (result_stall),
    .out_value  (new_value),
    .out_tag    (res_tag)
  );

  assign end_of_run = res_tag.end_of_run;
  assign frame_done = res_tag.frame_done;

  `FPSS_ASSERT(a_frame_ends_run, clk, rst, !(result_valid && frame_done) || end_of_run)
  `FPSS_ASSERT(a_frame_cell_zero, clk, rst, !(result_valid && frame_done) || new_value == '0)
  `FPSS_ASSERT_NEXT(a_flush_starts, clk, rst, sample_xfer && final_in, flush_cnt == FLUSH_LEN)
  `FPSS_ASSERT(a_no_take_in_flush, clk, rst, !(flushing && sample_xfer))

endmodule

>>> rtl/fpss_cell.sv
// One cell of the sample delay line: a register that loads its left neighbor.
// Depends on nothing else.
`timescale 1ns / 1ps

module fpss_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] d,
  output logic signed [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

>>> rtl/fpss_line.sv
// Two-row delay line built as a chain of fpss_cell, with the stencil taps.
// Depends on fpss_cell.
`timescale 1ns / 1ps

module fpss_line #(
  parameter int N = 32,
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] d,
  output logic signed [W-1:0] up,
  output logic signed [W-1:0] left,
  output logic signed [W-1:0] center,
  output logic signed [W-1:0] right
);

  localparam int DEPTH = 2 * N;

  logic signed [W-1:0] tap [DEPTH];

  // tap[i] holds the sample accepted i+1 transfers ago
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      fpss_cell #(.W(W)) u_cell (.clk(clk), .en(en), .d(d), .q(tap[i]));
    end else begin : g_body
      fpss_cell #(.W(W)) u_cell (.clk(clk), .en(en), .d(tap[i-1]), .q(tap[i]));
    end
  end

  assign up     = tap[DEPTH-1];
  assign left   = tap[N];
  assign center = tap[N-1];
  assign right  = tap[N-2];

endmodule

>>> rtl/fpss_datapath.sv
// Three-stage elastic pipeline: Laplacian sum, gain multiply, round and clamp (zero off interior).
// Depends on fpss_pkg for the tag type and gain width.
`timescale 1ns / 1ps

module fpss_datapath #(
  parameter int W = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [fpss_pkg::GAIN_BITS-1:0]  gain,
  input  logic                            push,
  output logic                            push_ready,
  input  logic signed [W-1:0]             up,
  input  logic signed [W-1:0]             down,
  input  logic signed [W-1:0]             left,
  input  logic signed [W-1:0]             right,
  input  logic signed [W-1:0]             center,
  input  fpss_pkg::tag_t                  tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [W-1:0]             out_value,
  output fpss_pkg::tag_t                  out_tag
);

  import fpss_pkg::*;

  localparam int LW = W + 3;              // Laplacian
  localparam int PW = LW + GAIN_BITS + 1; // gain * Laplacian, 16 fraction bits
  localparam int DW = PW - 16;            // rounded delta
  localparam int VW = W + 5;              // center + delta
  localparam logic signed [VW-1:0] VMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = ~VMAX;
  localparam logic signed [PW-1:0] HALF = PW'(32768);

  logic              v1, v2;
  logic              rdy1, rdy2, rdy3;
  logic signed [LW-1:0] lap1;
  logic signed [W-1:0]  u1, u2;
  tag_t                 tag1, tag2;
  logic signed [PW-1:0] prod2;

  logic signed [LW-1:0] lap_next;
  logic signed [PW-1:0] prod_next;
  logic signed [PW-1:0] rounded;
  logic signed [DW-1:0] delta;
  logic signed [VW-1:0] sum;
  logic signed [W-1:0]  value_next;

  assign rdy3 = !out_valid || !out_stall;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign push_ready = rdy1;

  always_comb begin
    lap_next = LW'(up) + LW'(down) + LW'(left) + LW'(right) - (LW'(center) <<< 2);
  end

  assign prod_next = $signed({1'b0, gain}) * lap1;

  // floor((p + 2^15) / 2^16): ties go toward plus infinity
  always_comb begin
    rounded = prod2 + HALF;
    delta   = rounded[PW-1:16];
    sum     = VW'(u2) + VW'(delta);
    if (!tag2.interior) begin
      value_next = '0;
    end else if (sum > VMAX) begin
      value_next = VMAX[W-1:0];
    end else if (sum < VMIN) begin
      value_next = VMIN[W-1:0];
    end else begin
      value_next = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= push;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && push) begin
      lap1 <= lap_next;
      u1   <= center;
      tag1 <= tag;
    end
    if (rdy2 && v1) begin
      prod2 <= prod_next;
      u2    <= u1;
      tag2  <= tag1;
    end
    if (rdy3 && v2) begin
      out_value <= value_next;
      out_tag   <= tag2;
    end
  end

endmodule
